@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int ID_W      = 16;
  localparam int PRI_W     = 8;
  localparam int DUR_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PLACE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [DUR_W-1:0] dur;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [ID_W-1:0] key;
    entry_t          ent;
  } cell_ctl_t;

endpackage

@@ src/spq_cell.sv @@
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    left_ent,
  input  logic               left_valid,
  input  logic               left_go,
  input  logic               left_seen,
  input  spq_pkg::entry_t    right_ent,
  input  logic               right_valid,
  output spq_pkg::entry_t    ent,
  output logic               valid,
  output logic               go,
  output logic               seen,
  output spq_pkg::entry_t    match_ent
);

  spq_pkg::entry_t ent_r, ent_nxt;
  logic            valid_r, valid_nxt;
  logic            hit;
  logic            first;

  // go forms a thermometer along the chain since entries stay sorted
  assign go        = !valid_r || (ent_r.pri > ctl.ent.pri);
  assign hit       = valid_r && (ent_r.id == ctl.key);
  assign seen      = hit || left_seen;
  assign first     = hit && !left_seen;
  assign match_ent = first ? ent_r : '0;
  assign ent       = ent_r;
  assign valid     = valid_r;

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    if (ctl.ins && go) begin
      if (left_go) begin
        ent_nxt   = left_ent;
        valid_nxt = left_valid;
      end else begin
        ent_nxt   = ctl.ent;
        valid_nxt = 1'b1;
      end
    end else if (ctl.rem && seen) begin
      ent_nxt   = right_ent;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ src/sorted_priority_task_queue.sv @@
// The accepting edge moves the FSM to S_EXEC, and out_valid is registered from that
// pass; change priority inserts S_PLACE before the strobe (remove pass, then placement pass).
// A new request is taken only while busy is low; busy drops in the
// cycle the result is shown, so the next start may coincide with the strobe.
// Each pass is one shift of the cell chain. The receiver cannot stall.
// Reset (synchronous, rst_n low) empties the queue at once; no clearing pass.
module sorted_priority_task_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [spq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [spq_pkg::ID_W-1:0]      in_task_id,
  input  logic [spq_pkg::PRI_W-1:0]     in_priority_req,
  input  logic [spq_pkg::DUR_W-1:0]     in_duration,
  output logic                          out_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::ID_W-1:0]      out_found_id,
  output logic [spq_pkg::PRI_W-1:0]     out_found_priority,
  output logic [spq_pkg::DUR_W-1:0]     out_found_duration,
  output logic [spq_pkg::CNT_OUT_W-1:0] out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_t    state_r, state_nxt;
  spq_pkg::cmd_t      cmd_r;
  logic [spq_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [spq_pkg::PRI_W-1:0] pri_r;
  logic [spq_pkg::DUR_W-1:0] dur_r, dur_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  spq_pkg::status_t              out_status_r, out_status_nxt;
  spq_pkg::entry_t               out_found_r, out_found_nxt;
  logic [spq_pkg::CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    cell_ent   [DEPTH];
  logic               cell_valid [DEPTH];
  logic               cell_go    [DEPTH];
  logic               cell_seen  [DEPTH];
  spq_pkg::entry_t    cell_match [DEPTH];
  spq_pkg::entry_t    found;
  logic               any_hit;
  logic               full;
  logic               accept;

  assign accept  = start && !busy;
  assign busy    = (state_r != spq_pkg::S_IDLE);
  assign full    = (count_r == CW'(DEPTH));
  assign any_hit = cell_seen[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t l_ent, r_ent;
    logic            l_valid, l_go, l_seen, r_valid;

    if (i == 0) begin : g_head
      assign l_ent   = '0;
      assign l_valid = 1'b1;
      assign l_go    = 1'b0;
      assign l_seen  = 1'b0;
    end else begin : g_body
      assign l_ent   = cell_ent[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_go    = cell_go[i-1];
      assign l_seen  = cell_seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_ent   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_ent   = cell_ent[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_ent    (l_ent),
      .left_valid  (l_valid),
      .left_go     (l_go),
      .left_seen   (l_seen),
      .right_ent   (r_ent),
      .right_valid (r_valid),
      .ent         (cell_ent[i]),
      .valid       (cell_valid[i]),
      .go          (cell_go[i]),
      .seen        (cell_seen[i]),
      .match_ent   (cell_match[i])
    );
  end

  // at most one cell reports a first match, the rest give zero
  always_comb begin
    found = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | cell_match[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) state_nxt = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        if (cmd_r == spq_pkg::CMD_MODIFY && any_hit) state_nxt = spq_pkg::S_PLACE;
        else state_nxt = spq_pkg::S_IDLE;
      end
      spq_pkg::S_PLACE: state_nxt = spq_pkg::S_IDLE;
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.key        = id_r;
    ctl.ent        = '{id: id_r, pri: pri_r, dur: dur_r};
    id_nxt         = id_r;
    dur_nxt        = dur_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = spq_pkg::ST_DONE;
    out_found_nxt  = '0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          id_nxt  = in_task_id;
          dur_nxt = in_duration;
        end
      end
      spq_pkg::S_EXEC: begin
        out_valid_nxt = 1'b1;
        case (cmd_r)
          spq_pkg::CMD_INSERT: begin
            if (full) begin
              out_status_nxt = spq_pkg::ST_FULL;
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = CW'(count_r + 1'b1);
            end
          end
          spq_pkg::CMD_FIND: begin
            if (any_hit) out_found_nxt = found;
            else out_status_nxt = spq_pkg::ST_NOT_FOUND;
          end
          default: begin
            if (any_hit) begin
              ctl.rem   = 1'b1;
              count_nxt = CW'(count_r - 1'b1);
              if (cmd_r == spq_pkg::CMD_MODIFY) begin
                // keep id and duration for the placement pass
                id_nxt        = found.id;
                dur_nxt       = found.dur;
                out_valid_nxt = 1'b0;
              end
            end else begin
              out_status_nxt = spq_pkg::ST_NOT_FOUND;
            end
          end
        endcase
      end
      spq_pkg::S_PLACE: begin
        ctl.ins       = 1'b1;
        count_nxt     = CW'(count_r + 1'b1);
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
    out_count_nxt = spq_pkg::CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= spq_pkg::cmd_t'(in_cmd);
      pri_r <= in_priority_req;
    end
    id_r  <= id_nxt;
    dur_r <= dur_nxt;
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_found_r  <= out_found_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_id       = out_found_r.id;
  assign out_found_priority = out_found_r.pri;
  assign out_found_duration = out_found_r.dur;
  assign out_entry_count    = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted request did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_FULL) |-> full && $stable(count_r))
    else $error("full status with free slot");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != spq_pkg::ST_DONE) |->
      (out_found_id == '0 && out_found_priority == '0 && out_found_duration == '0))
    else $error("found fields set on failed request");

endmodule

@@ tb/tb_sorted_priority_task_queue.sv @@
`timescale 1ns / 100ps

module tb_sorted_priority_task_queue;

  localparam int QUEUE_DEPTH  = spq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1320;
  localparam int MODE_SPAN    = 40;
  localparam int POOL_SIZE    = 12;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct {
    spq_pkg::cmd_t             cmd;
    logic [spq_pkg::ID_W-1:0]  id;
    logic [spq_pkg::PRI_W-1:0] pri;
    logic [spq_pkg::DUR_W-1:0] dur;
    int                        gap_pct;
  } request_t;

  typedef struct {
    spq_pkg::status_t              status;
    logic [spq_pkg::ID_W-1:0]      id;
    logic [spq_pkg::PRI_W-1:0]     pri;
    logic [spq_pkg::DUR_W-1:0]     dur;
    logic [spq_pkg::CNT_OUT_W-1:0] count;
  } response_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [spq_pkg::CMD_W-1:0]     in_cmd = '0;
  logic [spq_pkg::ID_W-1:0]      in_task_id = '0;
  logic [spq_pkg::PRI_W-1:0]     in_priority_req = '0;
  logic [spq_pkg::DUR_W-1:0]     in_duration = '0;
  logic                          out_valid;
  logic [spq_pkg::STATUS_W-1:0]  out_status;
  logic [spq_pkg::ID_W-1:0]      out_found_id;
  logic [spq_pkg::PRI_W-1:0]     out_found_priority;
  logic [spq_pkg::DUR_W-1:0]     out_found_duration;
  logic [spq_pkg::CNT_OUT_W-1:0] out_entry_count;

  request_t  pending_requests[$];
  response_t expected_responses[$];
  request_t  cur_req;
  request_t  accepted_req;
  logic      accepted_pulse = 1'b0;
  int        accepted_cnt = 0;
  int        total_requests = 0;
  int        errors = 0;
  int        cycle_count = 0;

  // shadow of the sorted store
  spq_pkg::entry_t shadow_slots[QUEUE_DEPTH];
  int              shadow_count = 0;

  sorted_priority_task_queue #(.DEPTH(QUEUE_DEPTH)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .in_priority_req    (in_priority_req),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_id       (out_found_id),
    .out_found_priority (out_found_priority),
    .out_found_duration (out_found_duration),
    .out_entry_count    (out_entry_count)
  );

  always #1 clk = ~clk;

  // new entry goes after all entries of lower or equal priority
  function automatic void place_entry(spq_pkg::entry_t ent);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_slots[pos].pri <= ent.pri) pos++;
    for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
    shadow_slots[pos] = ent;
    shadow_count++;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
    shadow_count--;
  endfunction

  function automatic response_t compute_response(request_t r);
    response_t       res;
    spq_pkg::entry_t ent;
    int              hit;
    res.status = spq_pkg::ST_DONE;
    res.id     = '0;
    res.pri    = '0;
    res.dur    = '0;
    if (r.cmd == spq_pkg::CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        ent.id  = r.id;
        ent.pri = r.pri;
        ent.dur = r.dur;
        place_entry(ent);
      end
    end else begin
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (hit < 0 && shadow_slots[i].id == r.id) hit = i;
      end
      if (hit < 0) begin
        res.status = spq_pkg::ST_NOT_FOUND;
      end else begin
        ent = shadow_slots[hit];
        case (r.cmd)
          spq_pkg::CMD_FIND: begin
            res.id  = ent.id;
            res.pri = ent.pri;
            res.dur = ent.dur;
          end
          spq_pkg::CMD_REMOVE: begin
            drop_slot(hit);
          end
          default: begin
            drop_slot(hit);
            ent.pri = r.pri;
            place_entry(ent);
          end
        endcase
      end
    end
    res.count = shadow_count[spq_pkg::CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic add_request(spq_pkg::cmd_t cmd, logic [spq_pkg::ID_W-1:0] id,
                             logic [spq_pkg::PRI_W-1:0] pri,
                             logic [spq_pkg::DUR_W-1:0] dur, int gap_pct);
    request_t r;
    r.cmd     = cmd;
    r.id      = id;
    r.pri     = pri;
    r.dur     = dur;
    r.gap_pct = gap_pct;
    pending_requests.push_back(r);
    total_requests++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : driver
    logic free;
    logic took;
    free = !start;
    took = start && !busy && rst_n;
    if (took) begin
      accepted_req <= cur_req;
      accepted_cnt++;
      free = 1'b1;
    end
    accepted_pulse <= took;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (free) begin
      if (pending_requests.size() > 0 &&
          $urandom_range(0, 99) >= pending_requests[0].gap_pct) begin
        cur_req = pending_requests.pop_front();
        start           <= 1'b1;
        in_cmd          <= cur_req.cmd;
        in_task_id      <= cur_req.id;
        in_priority_req <= cur_req.pri;
        in_duration     <= cur_req.dur;
      end else begin
        // idle: junk on the fields must be ignored
        start           <= 1'b0;
        in_cmd          <= spq_pkg::CMD_W'($urandom);
        in_task_id      <= spq_pkg::ID_W'($urandom);
        in_priority_req <= spq_pkg::PRI_W'($urandom);
        in_duration     <= spq_pkg::DUR_W'($urandom);
      end
    end
  end

  // check first, then predict the request flagged by accepted_pulse;
  // a response is never checked before its prediction is queued
  always @(posedge clk) begin : monitor
    response_t want;
    if (rst_n && out_valid) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response, status %0d count %0d", $time, out_status,
                 out_entry_count);
        errors++;
      end else begin
        want = expected_responses.pop_front();
        check_field("status", want.status, out_status);
        check_field("found_id", want.id, out_found_id);
        check_field("found_priority", want.pri, out_found_priority);
        check_field("found_duration", want.dur, out_found_duration);
        check_field("entry_count", want.count, out_entry_count);
      end
    end
    if (accepted_pulse) expected_responses.push_back(compute_response(accepted_req));
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [spq_pkg::ID_W-1:0] id_pool[POOL_SIZE];
    logic [spq_pkg::ID_W-1:0] id;
    logic [spq_pkg::PRI_W-1:0] pri;
    spq_pkg::cmd_t cmd;
    int gap;
    int roll;
    logic fill_mode;

    // empty store
    add_request(spq_pkg::CMD_FIND,   16'd5, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_REMOVE, 16'd5, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_MODIFY, 16'd5, 8'd9, 16'd0, 22);
    // field extremes, duplicate ids with equal priority
    add_request(spq_pkg::CMD_INSERT, 16'h0000, 8'h00, 16'h0000, 22);
    add_request(spq_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 22);
    add_request(spq_pkg::CMD_INSERT, 16'd7, 8'd10, 16'd1, 22);
    add_request(spq_pkg::CMD_INSERT, 16'd7, 8'd10, 16'd2, 22);
    add_request(spq_pkg::CMD_FIND,   16'd7, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_MODIFY, 16'd7, 8'hFF, 16'd0, 22);
    add_request(spq_pkg::CMD_FIND,   16'd7, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_REMOVE, 16'd7, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_FIND,   16'h0000, 8'd0, 16'd0, 22);
    add_request(spq_pkg::CMD_MODIFY, 16'hFFFF, 8'h00, 16'd0, 22);
    // fill up, then overflow and modify while full
    for (int i = 0; i < QUEUE_DEPTH - 3; i++)
      add_request(spq_pkg::CMD_INSERT, spq_pkg::ID_W'(100 + i),
                  spq_pkg::PRI_W'($urandom_range(0, 3)), spq_pkg::DUR_W'($urandom), 0);
    add_request(spq_pkg::CMD_INSERT, 16'hABCD, 8'd1, 16'd3, 22);
    add_request(spq_pkg::CMD_MODIFY, 16'd100, 8'd200, 16'd0, 22);
    add_request(spq_pkg::CMD_FIND,   16'd100, 8'd0, 16'd0, 22);

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = spq_pkg::ID_W'($urandom);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap = (n < RANDOM_ITEMS / 3) ? 22 : (n < 2 * RANDOM_ITEMS / 3) ? 63 : 0;
      // alternate fill-heavy and drain-heavy spans so the count sweeps empty to full
      fill_mode = ((n / MODE_SPAN) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (fill_mode)
        cmd = roll < 60 ? spq_pkg::CMD_INSERT : roll < 75 ? spq_pkg::CMD_FIND
            : roll < 85 ? spq_pkg::CMD_REMOVE : spq_pkg::CMD_MODIFY;
      else
        cmd = roll < 10 ? spq_pkg::CMD_INSERT : roll < 25 ? spq_pkg::CMD_FIND
            : roll < 85 ? spq_pkg::CMD_REMOVE : spq_pkg::CMD_MODIFY;
      id  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
          : id_pool[$urandom_range(0, POOL_SIZE - 1)];
      pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      add_request(cmd, id, pri, spq_pkg::DUR_W'($urandom), gap);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (accepted_cnt < total_requests || accepted_pulse ||
           expected_responses.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      errors++;
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sorted_priority_task_queue.f @@
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_task_queue.sv
tb/tb_sorted_priority_task_queue.sv
